@@ hw/rtl/array_bound_expression_folder_top_assert.svh @@
// Assertion macros for the array bound expression folder.
// Each macro expects clk and rst_n in scope.
`ifndef ARRAY_BOUND_EXPRESSION_FOLDER_TOP_ASSERT_SVH
`define ARRAY_BOUND_EXPRESSION_FOLDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ABEF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ABEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ABEF_ASSERT_NOW(label, ante, cons, msg)
`define ABEF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ hw/rtl/abef_pkg.sv @@
`default_nettype none
package abef_pkg;

    localparam int DATA_W  = 64;
    localparam int BOUND_W = 63;
    localparam int ITER_N  = DATA_W;
    localparam int CNT_W   = $clog2(ITER_N);

    // command codes
    localparam logic [1:0] CMD_NUMBER   = 2'd0;
    localparam logic [1:0] CMD_OPERATOR = 2'd1;
    localparam logic [1:0] CMD_END      = 2'd2;

    // operator codes
    localparam logic [1:0] OP_PLUS   = 2'd0;
    localparam logic [1:0] OP_MINUS  = 2'd1;
    localparam logic [1:0] OP_TIMES  = 2'd2;
    localparam logic [1:0] OP_DIVIDE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_WRAP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;   // item beat accepted
        logic step;   // one radix-2 iteration
        logic wrap;   // write back multiply/divide result
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic need_iter;  // offered number needs the iterative unit
        logic iter_last;  // final iteration this cycle
        logic out_full;   // result register occupied
    } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/abef_ctrl.sv @@
`default_nettype none
module abef_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire logic [1:0]    command,
    input  wire abef_pkg::sts_t sts,
    output logic               item_stall,
    output abef_pkg::ctl_t     ctl
);
    import abef_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                // end beats wait for a free result register
                item_stall = (command == CMD_END) && sts.out_full;
                ctl.take   = item_valid && !item_stall;
                if (ctl.take && sts.need_iter)
                begin
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                ctl.step = 1'b1;
                if (sts.iter_last)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                ctl.wrap   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/abef_dp.sv @@
`default_nettype none
module abef_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire abef_pkg::ctl_t                ctl,
    input  wire logic [1:0]                    command,
    input  wire logic [abef_pkg::DATA_W-1:0]   number_value,
    input  wire logic [1:0]                    operator_code,
    input  wire logic                          result_stall,
    output abef_pkg::sts_t                     sts,
    output logic                               result_valid,
    output logic [abef_pkg::BOUND_W-1:0]       bound_length,
    output logic                               overflow_error
);
    import abef_pkg::*;

    localparam logic [DATA_W+1:0] MAG_LIMIT = (DATA_W+2)'(1) << (DATA_W-1);

    // fold state
    logic [DATA_W-1:0]  sum_reg, sum_next;
    logic [DATA_W-1:0]  term_reg, term_next;
    logic [1:0]         op_reg, op_next;
    logic               seen_reg, seen_next;
    logic               err_reg, err_next;

    // iterative unit
    logic [DATA_W:0]    acc_reg, acc_next;     // product or remainder
    logic [DATA_W-1:0]  shreg_reg, shreg_next; // multiplier bits or dividend/quotient
    logic [DATA_W-1:0]  opnd_reg, opnd_next;   // |term| or divisor
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               div_reg, div_next;
    logic               neg_reg, neg_next;
    logic               big_reg, big_next;     // sticky product overflow

    // result register
    logic               rv_reg, rv_next;
    logic [BOUND_W-1:0] bound_reg, bound_next;
    logic               oerr_reg, oerr_next;

    logic [DATA_W-1:0]  sum_add;
    logic               add_ovf;
    logic [DATA_W-1:0]  term_mag;
    logic [DATA_W-1:0]  num_neg;
    logic               num_live;
    logic [DATA_W+1:0]  mul_t;
    logic [DATA_W:0]    rem_t;
    logic [DATA_W:0]    rem_d;
    logic               rem_ge;

    assign sum_add  = sum_reg + term_reg;
    assign add_ovf  = (sum_reg[DATA_W-1] == term_reg[DATA_W-1]) &&
                      (sum_add[DATA_W-1] != sum_reg[DATA_W-1]);
    assign term_mag = term_reg[DATA_W-1] ? (~term_reg + DATA_W'(1)) : term_reg;
    assign num_neg  = ~number_value + DATA_W'(1);
    assign num_live = !err_reg && (number_value != '0) && !number_value[DATA_W-1];

    assign mul_t  = {acc_reg, 1'b0} + {2'b00, opnd_reg};
    assign rem_t  = {acc_reg[DATA_W-1:0], shreg_reg[DATA_W-1]};
    assign rem_d  = rem_t - {1'b0, opnd_reg};
    assign rem_ge = rem_t >= {1'b0, opnd_reg};

    always_comb
    begin
        sts.need_iter = (command == CMD_NUMBER) && num_live && seen_reg &&
                        ((op_reg == OP_TIMES) || (op_reg == OP_DIVIDE));
        sts.iter_last = cnt_reg == CNT_W'(ITER_N - 1);
        sts.out_full  = rv_reg;
    end

    always_comb
    begin
        sum_next   = sum_reg;
        term_next  = term_reg;
        op_next    = op_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        acc_next   = acc_reg;
        shreg_next = shreg_reg;
        opnd_next  = opnd_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        big_next   = big_reg;
        rv_next    = rv_reg && result_stall;
        bound_next = bound_reg;
        oerr_next  = oerr_reg;

        if (ctl.take)
        begin
            case (command)
                CMD_NUMBER:
                begin
                    if (!err_reg && (number_value != '0))
                    begin
                        if (number_value[DATA_W-1])
                        begin
                            err_next = 1'b1;
                        end
                        else if (!seen_reg)
                        begin
                            term_next = number_value;
                            seen_next = 1'b1;
                        end
                        else if ((op_reg == OP_TIMES) || (op_reg == OP_DIVIDE))
                        begin
                            div_next  = op_reg == OP_DIVIDE;
                            neg_next  = term_reg[DATA_W-1];
                            big_next  = 1'b0;
                            acc_next  = '0;
                            cnt_next  = '0;
                            if (op_reg == OP_DIVIDE)
                            begin
                                shreg_next = term_mag;
                                opnd_next  = number_value;
                            end
                            else
                            begin
                                shreg_next = number_value;
                                opnd_next  = term_mag;
                            end
                        end
                        else if (add_ovf)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            sum_next  = sum_add;
                            term_next = (op_reg == OP_MINUS) ? num_neg : number_value;
                        end
                    end
                end
                CMD_OPERATOR:
                begin
                    op_next = operator_code;
                end
                CMD_END:
                begin
                    rv_next = 1'b1;
                    if (err_reg || (seen_reg && add_ovf))
                    begin
                        bound_next = '0;
                        oerr_next  = 1'b1;
                    end
                    else
                    begin
                        oerr_next  = 1'b0;
                        bound_next = (seen_reg && !sum_add[DATA_W-1]) ?
                                     sum_add[BOUND_W-1:0] : '0;
                    end
                    sum_next  = '0;
                    term_next = '0;
                    op_next   = OP_PLUS;
                    seen_next = 1'b0;
                    err_next  = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (div_reg)
            begin
                acc_next   = rem_ge ? rem_d : rem_t;
                shreg_next = {shreg_reg[DATA_W-2:0], rem_ge};
            end
            else
            begin
                shreg_next = {shreg_reg[DATA_W-2:0], 1'b0};
                if (!big_reg)
                begin
                    // MSB-first shift-add; once past 2^63 the product only grows
                    acc_next = shreg_reg[DATA_W-1] ? mul_t[DATA_W:0]
                                                   : {acc_reg[DATA_W-1:0], 1'b0};
                    if (shreg_reg[DATA_W-1] && (mul_t > MAG_LIMIT))
                    begin
                        big_next = 1'b1;
                    end
                    else if (!shreg_reg[DATA_W-1] && ({acc_reg, 1'b0} > MAG_LIMIT))
                    begin
                        big_next = 1'b1;
                    end
                end
            end
        end

        if (ctl.wrap)
        begin
            if (div_reg)
            begin
                term_next = neg_reg ? (~shreg_reg + DATA_W'(1)) : shreg_reg;
            end
            else if (big_reg || acc_reg[DATA_W] || (!neg_reg && acc_reg[DATA_W-1]))
            begin
                err_next = 1'b1;
            end
            else
            begin
                term_next = neg_reg ? (~acc_reg[DATA_W-1:0] + DATA_W'(1))
                                    : acc_reg[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            term_reg <= '0;
            op_reg   <= OP_PLUS;
            seen_reg <= 1'b0;
            err_reg  <= 1'b0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            term_reg <= term_next;
            op_reg   <= op_next;
            seen_reg <= seen_next;
            err_reg  <= err_next;
            rv_reg   <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        shreg_reg <= shreg_next;
        opnd_reg  <= opnd_next;
        cnt_reg   <= cnt_next;
        div_reg   <= div_next;
        neg_reg   <= neg_next;
        big_reg   <= big_next;
        bound_reg <= bound_next;
        oerr_reg  <= oerr_next;
    end

    assign result_valid   = rv_reg;
    assign bound_length   = bound_reg;
    assign overflow_error = oerr_reg;

endmodule
`default_nettype wire

@@ hw/rtl/array_bound_expression_folder_top.sv @@
// Array bound expression folder.
// Input channel (item_valid / item_stall): one token per beat on command,
// number_value and operator_code: a number, an operator, or end of bound.
// Output channel (result_valid / result_stall): one beat per end token,
// carrying bound_length and overflow_error.
// Handling per input beat:
//   operator, end, and numbers that set the term or fold by plus/minus: done on acceptance.
//   numbers folded by times or divide: a load, 64 radix-2 iterations of the
//   shared shift-add / restoring-divide unit, then a write-back.
// The 64 iterations of that single unit set the worst-case rate.
// An end beat's result appears on the output in the cycle after acceptance.
// The result sits in an output register: while the receiver stalls, later
// tokens are still accepted; only the next end beat is stalled until the
// pending result is taken.
// Reset (rst_n low, asynchronous) clears the fold state (sum, term,
// pending operator plus, flags) and empties the output register.
`default_nettype none
`include "array_bound_expression_folder_top_assert.svh"
module array_bound_expression_folder_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [1:0]                    command,
    input  wire logic [abef_pkg::DATA_W-1:0]   number_value,
    input  wire logic [1:0]                    operator_code,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [abef_pkg::BOUND_W-1:0]       bound_length,
    output logic                               overflow_error
);
    import abef_pkg::*;

    ctl_t ctl;   // sequencer commands
    sts_t sts;   // datapath status

    abef_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .command    (command),
        .sts        (sts),
        .item_stall (item_stall),
        .ctl        (ctl)
    );

    abef_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .command        (command),
        .number_value   (number_value),
        .operator_code  (operator_code),
        .result_stall   (result_stall),
        .sts            (sts),
        .result_valid   (result_valid),
        .bound_length   (bound_length),
        .overflow_error (overflow_error)
    );

    // an error result never carries a bound
    `ABEF_ASSERT_NOW(a_err_zero_bound, result_valid && overflow_error, bound_length == '0, "error result with nonzero bound")
    // no beat is taken while the iterative unit runs
    `ABEF_ASSERT_NOW(a_busy_stalls, ctl.step || ctl.wrap, item_stall, "input accepted while busy")
    // a times/divide number launches the iterative unit next cycle
    `ABEF_ASSERT_NEXT(a_launch, ctl.take && sts.need_iter, ctl.step && !ctl.take, "iterative unit not started")

endmodule
`default_nettype wire
